// File: hdl/mpdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpdc_pkg: shared definitions for the marker packet deframer and checker
// Packet kinds, verdict codes, marker values, packet lengths and the result
// record that passes from the checker core to the output register.
// ----------------------------------------------------------------------------
package mpdc_pkg;

  localparam int unsigned GEOM_MAX_VERTS = 16;   // 1..64
  localparam int unsigned GEOM_MAX_TRIS  = 16;   // 1..64
  localparam int unsigned TEX_ROW_TEXELS = 256;  // 16..256

  localparam int unsigned OFFSET_W = 11;

  // Marker bytes share their upper six bits; the low two bits give the kind.
  localparam logic [5:0] MARKER_PREFIX = 6'b101011;

  // Fixed packet lengths in bytes, marker included.
  localparam int unsigned LEN_ROT  = 37;
  localparam int unsigned LEN_MAT  = 66;
  localparam int unsigned LEN_GEOM = 4 + 6 * GEOM_MAX_VERTS + 15 * GEOM_MAX_TRIS;
  localparam int unsigned LEN_TEX  = 3 + 6 * TEX_ROW_TEXELS;

  typedef enum logic [1:0] {
    KIND_ROT  = 2'd0,
    KIND_MAT  = 2'd1,
    KIND_GEOM = 2'd2,
    KIND_TEX  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_CSUM  = 2'd1,
    ST_RANGE = 2'd2,
    ST_MAG   = 2'd3
  } status_t;

  typedef struct packed {
    logic                emit;
    kind_t               kind;
    logic [OFFSET_W-1:0] offset;
    logic [7:0]          data;
    logic                last;
    logic                accepted;
    status_t             status;
  } result_t;

  function automatic logic [OFFSET_W-1:0] pkt_length(input kind_t kind);
    logic [OFFSET_W-1:0] len;
    unique case (kind)
      KIND_ROT:  len = OFFSET_W'(LEN_ROT);
      KIND_MAT:  len = OFFSET_W'(LEN_MAT);
      KIND_GEOM: len = OFFSET_W'(LEN_GEOM);
      KIND_TEX:  len = OFFSET_W'(LEN_TEX);
      default:   len = OFFSET_W'(LEN_ROT);
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// File: hdl/marker_packet_deframer_checker_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// marker_packet_deframer_checker_top: marker-framed packet deframer/checker
// Turns a stream of received serial bytes into packet beats with kind,
// offset and a verdict on the final beat of each packet.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat on the slave side, flagged in
// tuser when it follows an idle gap. A flagged byte of 0xAC to 0xAF starts a
// packet of kind 0 to 3 with a fixed length (37, 66, 340 and 1539 bytes with
// the default package constants); any other flagged byte, and every byte
// after a packet has ended, is dropped without a beat until the next gap. A
// gap inside a packet abandons it without a verdict. Each packet byte leaves
// on the master side as one beat carrying its kind, offset and value; tlast
// marks the final byte, whose beat also carries the accept bit and the
// status (checksum errors take precedence over range errors). The block
// takes a byte in every cycle as long as the result side keeps up: there is
// an input register and an output register with the checks between them, so
// a byte is held in the input register, checked, and its beat is loaded into
// the output register when that register is free or being emptied. The
// running XOR, offset counter and check flags are updated as each byte is
// taken by the core, giving at most one beat per cycle while the master side keeps up.
// ----------------------------------------------------------------------------
module marker_packet_deframer_checker_top
  import mpdc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
  input  wire logic        s_axis_tuser,  // [0] after_gap
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // [10:0] byte_offset, [18:11] data_byte,
                                          // [19] accepted, [21:20] status, rest zero
  output logic [1:0]       m_axis_tuser,  // [1:0] packet_kind
  output logic             m_axis_tlast
);

  // Input register: holds the byte until the checker core can take it.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_gap;

  // Output register.
  logic       out_valid;
  result_t    out_res;

  logic       advance;
  result_t    core_res;

  // The core consumes the held byte whenever the output register is free
  // or being emptied this cycle; bytes that give no beat go through too.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_gap  <= s_axis_tuser;
    end
  end

  mpdc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .after_gap (in_gap),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && core_res.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_res.emit) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tdata  = {2'b00, out_res.status, out_res.accepted,
                          out_res.data, out_res.offset};

  // The final beat of a packet always sits at the packet's last offset.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (out_res.offset + OFFSET_W'(1) == pkt_length(out_res.kind)))
    else $error("final beat at wrong offset");

  // The accept bit agrees with the status on every final beat.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (out_res.accepted == (out_res.status == ST_OK)))
    else $error("accept bit disagrees with status");

  // Beats before the final one carry no verdict.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (!out_res.accepted && out_res.status == ST_OK))
    else $error("verdict on a non-final beat");

  // With the output register empty the block is always ready for a byte.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_axis_tready)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire

// File: hdl/mpdc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpdc_core: framing state and per-byte checks
// Holds the packet state, works out the result for the byte presented and
// updates the state when the byte is taken.
// ----------------------------------------------------------------------------
module mpdc_core
  import mpdc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  input  wire logic       after_gap,
  output result_t         res
);

  logic                receiving, receiving_next;
  kind_t               cur_kind, cur_kind_next;
  logic [OFFSET_W-1:0] position, position_next;
  logic [7:0]          running_xor, running_xor_next;
  logic                range_ok, range_ok_next;
  logic                magnitude_ok, magnitude_ok_next;

  logic [OFFSET_W-1:0] pos_inc;
  logic [OFFSET_W:0]   pos_end;
  logic                is_final;
  status_t             verdict;

  assign pos_inc  = position + OFFSET_W'(1);
  assign pos_end  = {1'b0, pos_inc} + (OFFSET_W+1)'(1);
  assign is_final = pos_end >= {1'b0, pkt_length(cur_kind)};

  always_comb begin
    receiving_next    = receiving;
    cur_kind_next     = cur_kind;
    position_next     = position;
    running_xor_next  = running_xor;
    range_ok_next     = range_ok;
    magnitude_ok_next = magnitude_ok;
    verdict           = ST_OK;
    res               = '0;

    if (after_gap) begin
      if (rx_byte[7:2] == MARKER_PREFIX) begin
        receiving_next    = 1'b1;
        cur_kind_next     = kind_t'(rx_byte[1:0]);
        position_next     = '0;
        running_xor_next  = '0;
        range_ok_next     = 1'b1;
        magnitude_ok_next = 1'b1;
        res.emit          = 1'b1;
        res.kind          = kind_t'(rx_byte[1:0]);
        res.offset        = '0;
        res.data          = rx_byte;
      end else begin
        receiving_next = 1'b0;
      end
    end else if (receiving) begin
      position_next = pos_inc;

      // Top byte of each rotation word must keep bit 6 clear.
      if (cur_kind == KIND_ROT && pos_inc[1:0] == 2'b00 && rx_byte[6])
        magnitude_ok_next = 1'b0;
      if (cur_kind == KIND_GEOM) begin
        if (pos_inc == OFFSET_W'(1) &&
            (rx_byte == 8'd0 || rx_byte > 8'(GEOM_MAX_VERTS)))
          range_ok_next = 1'b0;
        if (pos_inc == OFFSET_W'(2) &&
            (rx_byte == 8'd0 || rx_byte > 8'(GEOM_MAX_TRIS)))
          range_ok_next = 1'b0;
      end
      if (cur_kind == KIND_TEX && pos_inc == OFFSET_W'(1) &&
          {1'b0, rx_byte} >= 9'(TEX_ROW_TEXELS))
        range_ok_next = 1'b0;

      if (is_final) begin
        receiving_next = 1'b0;
        priority if (cur_kind == KIND_ROT)
          verdict = magnitude_ok_next ? ST_OK : ST_MAG;
        else if (running_xor != rx_byte)
          verdict = ST_CSUM;
        else if (!range_ok_next)
          verdict = ST_RANGE;
        else
          verdict = ST_OK;
      end else begin
        running_xor_next = running_xor ^ rx_byte;
      end

      res.emit     = 1'b1;
      res.kind     = cur_kind;
      res.offset   = pos_inc;
      res.data     = rx_byte;
      res.last     = is_final;
      res.accepted = is_final && (verdict == ST_OK);
      res.status   = verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving    <= 1'b0;
      cur_kind     <= KIND_ROT;
      position     <= '0;
      running_xor  <= '0;
      range_ok     <= 1'b1;
      magnitude_ok <= 1'b1;
    end else if (step) begin
      receiving    <= receiving_next;
      cur_kind     <= cur_kind_next;
      position     <= position_next;
      running_xor  <= running_xor_next;
      range_ok     <= range_ok_next;
      magnitude_ok <= magnitude_ok_next;
    end
  end

endmodule
`default_nettype wire
